// ----- hdl/sas_pkg.sv -----
// Package for the shell argument splitter: transaction payload types, the
// splitter mode encoding and the byte constants that the decoder compares against.
// No dependencies.
package sas_pkg;

	localparam int MAX_RESULTS = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       token_done;
		logic       last_of_run;
	} out_item_t;

	// All results caused by one input byte, in output order.
	typedef struct packed {
		logic [1:0]                  count;
		out_item_t [MAX_RESULTS-1:0] item;
	} bundle_t;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_PLAIN = 3'd1,
		MODE_SQ    = 3'd2,
		MODE_DQ    = 3'd3,
		MODE_DQ_BS = 3'd4,
		MODE_BS    = 3'd5
	} mode_t;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_VT     = 8'h0b;
	localparam logic [7:0] CH_FF     = 8'h0c;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF ||
			c == CH_CR || c == CH_VT || c == CH_FF;
	endfunction

endpackage

// ----- hdl/sas_decode.sv -----
// Combinational decoder of the shell argument splitter: one byte and the current
// mode give the results of that byte and the next mode. Depends on sas_pkg.
module sas_decode (
	input  sas_pkg::mode_t    mode,
	input  sas_pkg::in_item_t item,
	output sas_pkg::bundle_t  bundle,
	output sas_pkg::mode_t    next_mode
);
	import sas_pkg::*;

	always_comb begin
		logic [1:0] cnt;
		mode_t      m;
		logic [7:0] c;
		logic       last;

		c      = item.in_byte;
		last   = item.end_of_string;
		cnt    = 2'd0;
		m      = mode;
		bundle = '0;

		unique case (mode)
			MODE_SQ: begin
				if (c == CH_SQUOTE) begin
					m = MODE_PLAIN;
				end else begin
					bundle.item[cnt].out_char = c;
					cnt = cnt + 2'd1;
				end
			end
			MODE_DQ: begin
				if (c == CH_DQUOTE) begin
					m = MODE_PLAIN;
				end else if (c == CH_BSLASH && !last) begin
					m = MODE_DQ_BS;
				end else begin
					bundle.item[cnt].out_char = c;
					cnt = cnt + 2'd1;
				end
			end
			MODE_DQ_BS: begin
				// Only a double quote or a backslash is escaped; otherwise the
				// backslash is kept ahead of the byte.
				if (c != CH_DQUOTE && c != CH_BSLASH) begin
					bundle.item[cnt].out_char = CH_BSLASH;
					cnt = cnt + 2'd1;
				end
				bundle.item[cnt].out_char = c;
				cnt = cnt + 2'd1;
				m = MODE_DQ;
			end
			MODE_BS: begin
				bundle.item[cnt].out_char = c;
				cnt = cnt + 2'd1;
				m = MODE_PLAIN;
			end
			default: begin
				// Idle or plain; the unused codes behave as idle.
				if (is_space(c)) begin
					if (mode == MODE_PLAIN) begin
						bundle.item[cnt].token_done = 1'b1;
						cnt = cnt + 2'd1;
					end
					m = MODE_IDLE;
				end else if (c == CH_SQUOTE) begin
					m = MODE_SQ;
				end else if (c == CH_DQUOTE) begin
					m = MODE_DQ;
				end else if (c == CH_BSLASH && !last) begin
					m = MODE_BS;
				end else begin
					bundle.item[cnt].out_char = c;
					cnt = cnt + 2'd1;
					m = MODE_PLAIN;
				end
			end
		endcase

		// End of string closes any open token.
		if (last) begin
			if (m != MODE_IDLE) begin
				bundle.item[cnt].token_done = 1'b1;
				cnt = cnt + 2'd1;
			end
			m = MODE_IDLE;
		end

		if (cnt != 2'd0) begin
			bundle.item[cnt - 2'd1].last_of_run = 1'b1;
		end
		bundle.count = cnt;
		next_mode    = m;
	end

endmodule

// ----- hdl/sas_out_queue.sv -----
// Result register of the shell argument splitter: holds the results of one byte
// and hands them out one transaction per cycle while out_ready is high. Depends on sas_pkg.
module sas_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  sas_pkg::bundle_t    bundle,
	output logic                free,
	output logic                out_valid,
	input  logic                out_ready,
	output sas_pkg::out_item_t  out_data
);
	import sas_pkg::*;

	logic       valid_s2;
	bundle_t    bundle_s2;
	logic [1:0] idx_q;
	logic       take_last;

	assign out_valid = valid_s2;
	assign out_data  = bundle_s2.item[idx_q];
	assign take_last = valid_s2 && out_ready && out_data.last_of_run;
	assign free      = !valid_s2 || take_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q    <= 2'd0;
		end else if (take_last) begin
			valid_s2 <= 1'b0;
		end else if (valid_s2 && out_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bundle_s2 <= bundle;
		end
	end

`ifndef SYNTHESIS
	a_no_empty_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> bundle_s2.count != 2'd0)
		else $error("result register holds an empty bundle");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> idx_q < bundle_s2.count)
		else $error("result index ran past the bundle");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("bundle loaded over results not yet delivered");

	a_done_has_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.token_done |-> out_data.out_char == 8'h00)
		else $error("token end carries a character");
`endif

endmodule

// ----- hdl/shell_argument_splitter.sv -----
// Top level of the shell argument splitter: input register, mode register,
// decoder and result register. Depends on sas_pkg, sas_decode and sas_out_queue.
//
// Usage: the input channel (in_valid, in_ready, in_data) takes one byte of a
// command-line string per transaction, with end_of_string set on its final byte.
// The output channel (out_valid, out_ready, out_data) gives the tokens as runs of
// character transactions, each run closed by a transaction with token_done set.
// Each byte causes zero to three result transactions; last_of_run marks the
// final one caused by a byte.
//
// A byte accepted on the input channel is registered in the input register and
// decoded there; once the result register is free, its results are loaded into
// it and presented from there.
// Throughput: one byte per cycle while each byte gives at most one result and
// the receiver does not stall. The output port moves one result per cycle while
// out_ready is high, so a byte with two or three results keeps the result
// register busy while the next byte waits in the input register; bytes with no
// result pass without touching it.
//
// Reset clears all valid flags and puts the splitter between tokens. When the
// receiver stalls, the result register holds, the input register fills behind
// it and in_ready drops; nothing is lost or repeated.
module shell_argument_splitter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sas_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output sas_pkg::out_item_t out_data
);
	import sas_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;
	mode_t    mode_q;
	mode_t    next_mode;
	bundle_t  bundle;
	logic     q_free;
	logic     advance;
	logic     load;

	// The byte in the input register moves on when its results fit in the
	// result register, or at once when it has none.
	assign advance  = valid_s1 && (bundle.count == 2'd0 || q_free);
	assign load     = advance && bundle.count != 2'd0;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= MODE_IDLE;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				mode_q <= next_mode;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	sas_decode u_decode (
		.mode      (mode_q),
		.item      (item_s1),
		.bundle    (bundle),
		.next_mode (next_mode)
	);

	sas_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.bundle    (bundle),
		.free      (q_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_idle_after_string: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.end_of_string |=> mode_q == MODE_IDLE)
		else $error("splitter not between tokens after end of string");

	a_mode_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> $stable(mode_q))
		else $error("mode changed while the byte was held");

	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && bundle.count != 2'd0 |->
			bundle.item[bundle.count - 2'd1].last_of_run)
		else $error("final result of a byte is not marked");
`endif

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the shell argument splitter: streams command-line strings
// through the byte channel and checks every token transaction against a built-in predictor.
// Depends on sas_pkg and shell_argument_splitter.
module tb_top;
	import sas_pkg::*;

	localparam int STALL_PCT      = 31;
	localparam int RANDOM_BYTES   = 234;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 8;

	typedef logic [7:0] byte_q_t[$];

	// The scoreboard predicts the token transactions for each accepted byte and
	// holds them, oldest first, until the block presents them.
	class token_scoreboard;
		mode_t     mode;
		out_item_t pending_results[$];
		int        failures;
		int        bytes_seen;
		int        strings_seen;
		int        results_seen;
		int        tokens_expected;
		int        widest_burst;

		function new();
			mode            = MODE_IDLE;
			failures        = 0;
			bytes_seen      = 0;
			strings_seen    = 0;
			results_seen    = 0;
			tokens_expected = 0;
			widest_burst    = 0;
		endfunction

		static function bit is_blank(logic [7:0] c);
			case (c)
				CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_VT, CH_FF: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		static function out_item_t piece(logic [7:0] c, logic done);
			out_item_t r;
			r.out_char    = c;
			r.token_done  = done;
			r.last_of_run = 1'b0;
			return r;
		endfunction

		// Advances the splitter mode by one byte and queues what that byte causes.
		function void note_byte(in_item_t it);
			out_item_t  burst[$];
			logic [7:0] c;
			logic       eos;
			mode_t      m;
			c   = it.in_byte;
			eos = it.end_of_string;
			m   = mode;
			bytes_seen++;
			case (m)
				MODE_SQ: begin
					if (c == CH_SQUOTE)
						m = MODE_PLAIN;
					else
						burst = {burst, piece(c, 1'b0)};
				end
				MODE_DQ: begin
					if (c == CH_DQUOTE)
						m = MODE_PLAIN;
					else if (c == CH_BSLASH && !eos)
						m = MODE_DQ_BS;
					else
						burst = {burst, piece(c, 1'b0)};
				end
				MODE_DQ_BS: begin
					// Only a quote or a backslash is really escaped here.
					if (c != CH_DQUOTE && c != CH_BSLASH)
						burst = {burst, piece(CH_BSLASH, 1'b0)};
					burst = {burst, piece(c, 1'b0)};
					m = MODE_DQ;
				end
				MODE_BS: begin
					burst = {burst, piece(c, 1'b0)};
					m = MODE_PLAIN;
				end
				default: begin
					if (is_blank(c)) begin
						if (m == MODE_PLAIN)
							burst = {burst, piece(8'h00, 1'b1)};
						m = MODE_IDLE;
					end else if (c == CH_SQUOTE) begin
						m = MODE_SQ;
					end else if (c == CH_DQUOTE) begin
						m = MODE_DQ;
					end else if (c == CH_BSLASH && !eos) begin
						m = MODE_BS;
					end else begin
						burst = {burst, piece(c, 1'b0)};
						m = MODE_PLAIN;
					end
				end
			endcase
			if (eos) begin
				if (m != MODE_IDLE)
					burst = {burst, piece(8'h00, 1'b1)};
				m = MODE_IDLE;
				strings_seen++;
			end
			mode = m;
			if (burst.size() > 0)
				burst[burst.size() - 1].last_of_run = 1'b1;
			if (burst.size() > widest_burst)
				widest_burst = burst.size();
			foreach (burst[i]) begin
				if (burst[i].token_done)
					tokens_expected++;
				pending_results = {pending_results, burst[i]};
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: out_char %02h token_done %0b last_of_run %0b",
					got.out_char, got.token_done, got.last_of_run);
				failures++;
				return;
			end
			want = pending_results.pop_front();
			if (got.out_char !== want.out_char) begin
				$error("out_char: expected %02h, got %02h", want.out_char, got.out_char);
				failures++;
			end
			if (got.token_done !== want.token_done) begin
				$error("token_done: expected %0b, got %0b", want.token_done, got.token_done);
				failures++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %0b, got %0b", want.last_of_run,
					got.last_of_run);
				failures++;
			end
		endfunction

		function void close();
			if (pending_results.size() != 0) begin
				$error("%0d expected results never arrived", pending_results.size());
				failures++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	// While calm is set neither side idles; it gives a long back-to-back stretch.
	bit              calm        = 1'b0;
	int              quiet_cycles = 0;
	token_scoreboard sb           = new();

	shell_argument_splitter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Both channels are observed in one process at the rising edge, so the values
	// read here are the ones that were stable before the edge. The byte channel is
	// noted before the result channel is checked; a byte accepted at this edge can
	// never have caused the result that is leaving at the same edge anyway.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_byte(in_data);
			if (out_valid && out_ready)
				sb.check_result(out_data);
			quiet_cycles <= ((in_valid && in_ready) || (out_valid && out_ready)) ?
				0 : quiet_cycles + 1;
			// The receiver stalls at random, except inside the calm stretch.
			out_ready <= calm || ($urandom_range(99) >= STALL_PCT);
		end
	end

	// A run that stops moving transactions in either direction has hung.
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	// Presents one byte and returns at the edge where it was accepted. Valid is
	// only lowered when the sender decides to idle, so back-to-back transactions
	// keep it high without a glitch.
	task automatic send_byte(input logic [7:0] b, input logic eos);
		if (!calm) begin
			while ($urandom_range(99) < STALL_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_data.in_byte       <= b;
		in_data.end_of_string <= eos;
		in_valid              <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic send_string(input byte_q_t s);
		foreach (s[i])
			send_byte(s[i], i == s.size() - 1);
	endtask

	// Holds the byte channel idle until every predicted result has come out.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending_results.size() != 0);
	endtask

	// Random bytes lean toward the characters that steer the splitter: blanks,
	// both quotes and the backslash. The rest is letters and the full byte range.
	function automatic logic [7:0] random_byte();
		int pick;
		pick = $urandom_range(99);
		if (pick < 15) begin
			case ($urandom_range(5))
				0: return CH_SPACE;
				1: return CH_TAB;
				2: return CH_LF;
				3: return CH_CR;
				4: return CH_VT;
				default: return CH_FF;
			endcase
		end
		if (pick < 25)
			return CH_SQUOTE;
		if (pick < 36)
			return CH_DQUOTE;
		if (pick < 48)
			return CH_BSLASH;
		if (pick < 80)
			return 8'($urandom_range(8'h61, 8'h7a));
		return 8'($urandom_range(255));
	endfunction

	initial begin
		byte_q_t str;
		int      sent_random;
		int      len;
		bit      paused_mid;

		sent_random = 0;
		paused_mid  = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings. The first walks five blanks between tokens, a
		// single-quoted space, an empty double-quoted pair and the byte extremes.
		str = {8'hff, CH_TAB, CH_SQUOTE, CH_SPACE, CH_SQUOTE, CH_VT, CH_DQUOTE,
			CH_DQUOTE, CH_FF, CH_CR, CH_LF, 8'h00};
		send_string(str);
		// Escapes inside double quotes: an escaped quote, an escaped backslash and
		// a backslash before an ordinary byte, then an unquoted escape and a
		// trailing backslash outside quotes.
		str = {CH_DQUOTE, CH_BSLASH, CH_DQUOTE, CH_BSLASH, CH_BSLASH, CH_BSLASH,
			8'h78, CH_DQUOTE, CH_BSLASH, 8'h79, CH_BSLASH};
		send_string(str);
		// Unterminated double quote ending in a backslash that is kept.
		str = {CH_DQUOTE, CH_BSLASH};
		send_string(str);
		// A lone opening quote at the end still makes an empty token.
		str = {CH_SQUOTE};
		send_string(str);

		wait_for_drain();

		// Random strings, mostly short. A calm stretch in the middle runs with
		// no idling on either side, and the sender drains once more later on.
		while (sent_random < RANDOM_BYTES) begin
			calm = (sent_random >= 90 && sent_random < 160);
			if (!paused_mid && sent_random >= 180) begin
				wait_for_drain();
				paused_mid = 1'b1;
			end
			len = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 10);
			for (int i = 0; i < len; i++)
				send_byte(random_byte(), i == len - 1);
			sent_random += len;
		end
		calm = 1'b0;

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.close();

		$display("Covered %0d strings in %0d bytes, giving %0d results and %0d tokens.",
			sb.strings_seen, sb.bytes_seen, sb.results_seen, sb.tokens_expected);
		$display("Widest burst from a single byte: %0d results.", sb.widest_burst);
		if (sb.failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/sas_pkg.sv
hdl/sas_decode.sv
hdl/sas_out_queue.sv
hdl/shell_argument_splitter.sv
sim/tb_top.sv
